// ----- src/lcdseq_pkg.sv -----
// Shared types, codes and constants for the panel draw-command sequencer.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package lcdseq_pkg;

   // request kinds
   localparam logic [2:0] KIND_SET_PIXEL  = 3'd0;
   localparam logic [2:0] KIND_FILL_RECT  = 3'd1;
   localparam logic [2:0] KIND_DRAW_LINE  = 3'd2;
   localparam logic [2:0] KIND_OPEN_AREA  = 3'd3;
   localparam logic [2:0] KIND_PUSH_PIXEL = 3'd4;

   // panel controller commands
   localparam logic [15:0] CMD_COLUMN_ADDR = 16'h002a;
   localparam logic [15:0] CMD_PAGE_ADDR   = 16'h002b;
   localparam logic [15:0] CMD_MEMORY_WR   = 16'h002c;

   // configuration register indexes and reset values
   localparam logic        CSR_PANEL_WIDTH  = 1'b0;
   localparam logic        CSR_PANEL_HEIGHT = 1'b1;
   localparam logic [15:0] PANEL_WIDTH_RESET  = 16'd320;
   localparam logic [15:0] PANEL_HEIGHT_RESET = 16'd480;

   // word sequence shapes
   localparam logic [1:0] SEQ_NO_WRITE    = 2'd0;  // one empty word
   localparam logic [1:0] SEQ_WINDOW      = 2'd1;  // eleven window words
   localparam logic [1:0] SEQ_WINDOW_DATA = 2'd2;  // window words, then color
   localparam logic [1:0] SEQ_DATA        = 2'd3;  // one data word

   // word slots within a window sequence
   localparam logic [3:0] SLOT_COLUMN_CMD = 4'd0;
   localparam logic [3:0] SLOT_X1_HI      = 4'd1;
   localparam logic [3:0] SLOT_X1_LO      = 4'd2;
   localparam logic [3:0] SLOT_X2_HI      = 4'd3;
   localparam logic [3:0] SLOT_X2_LO      = 4'd4;
   localparam logic [3:0] SLOT_PAGE_CMD   = 4'd5;
   localparam logic [3:0] SLOT_Y1_HI      = 4'd6;
   localparam logic [3:0] SLOT_Y1_LO      = 4'd7;
   localparam logic [3:0] SLOT_Y2_HI      = 4'd8;
   localparam logic [3:0] SLOT_Y2_LO      = 4'd9;
   localparam logic [3:0] SLOT_MEMORY_CMD = 4'd10;
   localparam logic [3:0] SLOT_COLOR      = 4'd11;
   localparam logic [3:0] SLOT_FIRST      = 4'd0;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] x_start;
      logic [15:0] y_start;
      logic [15:0] x_end;
      logic [15:0] y_end;
      logic [15:0] color;
      logic        transparent;
   } request_type;

   typedef struct packed {
      logic [1:0]  seq;
      logic        status;
      logic [15:0] x1;
      logic [15:0] y1;
      logic [15:0] x2;
      logic [15:0] y2;
      logic [15:0] data_value;
      logic [32:0] data_count;
   } plan_type;

   // upper byte of a coordinate, sign carried into the top byte
   function automatic logic [15:0] high_byte(input logic [15:0] v);
      high_byte = {{8{v[15]}}, v[15:8]};
   endfunction

endpackage

`default_nettype wire

// ----- src/lcdseq_planner.sv -----
// Turns one registered draw request into a word-sequence plan: corner sort,
// bounds and axis checks for lines, and the fill pixel count. Uses lcdseq_pkg.
`default_nettype none

module lcdseq_planner (
   input  wire lcdseq_pkg::request_type req,
   input  wire [15:0]                   panel_width,
   input  wire [15:0]                   panel_height,
   output lcdseq_pkg::plan_type         plan
);

   logic [15:0] x_lo, x_hi, y_lo, y_hi;
   logic [16:0] dx, dy;
   logic [33:0] area;
   logic        start_inside, end_inside, on_axis;

   always_comb begin
      x_lo = ($signed(req.x_end) < $signed(req.x_start)) ? req.x_end : req.x_start;
      x_hi = ($signed(req.x_end) < $signed(req.x_start)) ? req.x_start : req.x_end;
      y_lo = ($signed(req.y_end) < $signed(req.y_start)) ? req.y_end : req.y_start;
      y_hi = ($signed(req.y_end) < $signed(req.y_start)) ? req.y_start : req.y_end;
      dx   = {x_hi[15], x_hi} - {x_lo[15], x_lo} + 17'd1;
      dy   = {y_hi[15], y_hi} - {y_lo[15], y_lo} + 17'd1;
      area = {17'd0, dx} * {17'd0, dy};

      start_inside = !req.x_start[15] && (req.x_start < panel_width) &&
                     !req.y_start[15] && (req.y_start < panel_height);
      end_inside   = !req.x_end[15] && (req.x_end < panel_width) &&
                     !req.y_end[15] && (req.y_end < panel_height);
      on_axis      = (req.x_start == req.x_end) || (req.y_start == req.y_end);
   end

   always_comb begin
      plan.seq        = lcdseq_pkg::SEQ_NO_WRITE;
      plan.status     = 1'b1;
      plan.x1         = req.x_start;
      plan.y1         = req.y_start;
      plan.x2         = req.x_end;
      plan.y2         = req.y_end;
      plan.data_value = req.color;
      plan.data_count = 33'd1;
      unique case (req.kind)
         lcdseq_pkg::KIND_SET_PIXEL: begin
            plan.status = 1'b0;
            if (!req.transparent) begin
               plan.seq = lcdseq_pkg::SEQ_WINDOW_DATA;
               plan.x2  = req.x_start;
               plan.y2  = req.y_start;
            end
         end
         lcdseq_pkg::KIND_FILL_RECT, lcdseq_pkg::KIND_DRAW_LINE: begin
            if (req.transparent) begin
               plan.status = 1'b0;
            end else if ((req.kind == lcdseq_pkg::KIND_FILL_RECT) ||
                         (start_inside && end_inside && on_axis)) begin
               plan.seq        = lcdseq_pkg::SEQ_WINDOW_DATA;
               plan.status     = 1'b0;
               plan.x1         = x_lo;
               plan.y1         = y_lo;
               plan.x2         = x_hi;
               plan.y2         = y_hi;
               plan.data_count = area[32:0];
            end
         end
         lcdseq_pkg::KIND_OPEN_AREA: begin
            plan.seq    = lcdseq_pkg::SEQ_WINDOW;
            plan.status = 1'b0;
         end
         lcdseq_pkg::KIND_PUSH_PIXEL: begin
            plan.seq        = lcdseq_pkg::SEQ_DATA;
            plan.status     = 1'b0;
            plan.data_value = req.transparent ? 16'h0000 : req.color;
         end
         default: begin
            plan.seq = lcdseq_pkg::SEQ_NO_WRITE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- src/lcdseq_emitter.sv -----
// Holds one plan and steps a slot counter through its words, one word per
// cycle into the response register unless a low rsp_ready holds it. Uses lcdseq_pkg.
`default_nettype none

module lcdseq_emitter (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       plan_valid,
   input  wire lcdseq_pkg::plan_type plan,
   output logic                      plan_take,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output logic                      rsp_is_command,
   output logic [15:0]               rsp_bus_value,
   output logic [32:0]               rsp_repeat_count,
   output logic                      rsp_status,
   output logic                      rsp_last
);

   lcdseq_pkg::plan_type plan_ff, plan_in;
   logic [3:0]  slot_ff, slot_in;
   logic        busy_ff, busy_in;
   logic        out_valid_ff, out_valid_in;
   logic        out_is_command_ff;
   logic [15:0] out_bus_value_ff;
   logic [32:0] out_repeat_count_ff;
   logic        out_status_ff, out_last_ff;

   logic        out_free, step, slot_last;
   logic [3:0]  last_slot;
   logic        res_is_command;
   logic [15:0] res_bus_value;
   logic [32:0] res_repeat_count;

   always_comb begin
      unique case (plan_ff.seq)
         lcdseq_pkg::SEQ_WINDOW:      last_slot = lcdseq_pkg::SLOT_MEMORY_CMD;
         lcdseq_pkg::SEQ_WINDOW_DATA: last_slot = lcdseq_pkg::SLOT_COLOR;
         default:                     last_slot = lcdseq_pkg::SLOT_FIRST;
      endcase
      out_free  = !out_valid_ff || rsp_ready;
      step      = busy_ff && out_free;
      slot_last = (slot_ff == last_slot);
      plan_take = plan_valid && (!busy_ff || (step && slot_last));
   end

   // word for the current slot
   always_comb begin
      res_is_command   = 1'b0;
      res_bus_value    = 16'h0000;
      res_repeat_count = 33'd1;
      unique case (plan_ff.seq)
         lcdseq_pkg::SEQ_NO_WRITE: begin
            res_repeat_count = 33'd0;
         end
         lcdseq_pkg::SEQ_DATA: begin
            res_bus_value    = plan_ff.data_value;
            res_repeat_count = plan_ff.data_count;
         end
         default: begin
            unique case (slot_ff)
               lcdseq_pkg::SLOT_COLUMN_CMD: begin
                  res_is_command = 1'b1;
                  res_bus_value  = lcdseq_pkg::CMD_COLUMN_ADDR;
               end
               lcdseq_pkg::SLOT_X1_HI: res_bus_value = lcdseq_pkg::high_byte(plan_ff.x1);
               lcdseq_pkg::SLOT_X1_LO: res_bus_value = plan_ff.x1;
               lcdseq_pkg::SLOT_X2_HI: res_bus_value = lcdseq_pkg::high_byte(plan_ff.x2);
               lcdseq_pkg::SLOT_X2_LO: res_bus_value = plan_ff.x2;
               lcdseq_pkg::SLOT_PAGE_CMD: begin
                  res_is_command = 1'b1;
                  res_bus_value  = lcdseq_pkg::CMD_PAGE_ADDR;
               end
               lcdseq_pkg::SLOT_Y1_HI: res_bus_value = lcdseq_pkg::high_byte(plan_ff.y1);
               lcdseq_pkg::SLOT_Y1_LO: res_bus_value = plan_ff.y1;
               lcdseq_pkg::SLOT_Y2_HI: res_bus_value = lcdseq_pkg::high_byte(plan_ff.y2);
               lcdseq_pkg::SLOT_Y2_LO: res_bus_value = plan_ff.y2;
               lcdseq_pkg::SLOT_MEMORY_CMD: begin
                  res_is_command = 1'b1;
                  res_bus_value  = lcdseq_pkg::CMD_MEMORY_WR;
               end
               lcdseq_pkg::SLOT_COLOR: begin
                  res_bus_value    = plan_ff.data_value;
                  res_repeat_count = plan_ff.data_count;
               end
               default: begin
                  res_repeat_count = 33'd0;
               end
            endcase
         end
      endcase
   end

   always_comb begin
      plan_in      = plan_take ? plan : plan_ff;
      busy_in      = plan_take ? 1'b1 : ((step && slot_last) ? 1'b0 : busy_ff);
      slot_in      = plan_take ? lcdseq_pkg::SLOT_FIRST : (step ? slot_ff + 4'd1 : slot_ff);
      out_valid_in = step ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         slot_ff      <= lcdseq_pkg::SLOT_FIRST;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         slot_ff      <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
      if (step) begin
         out_is_command_ff   <= res_is_command;
         out_bus_value_ff    <= res_bus_value;
         out_repeat_count_ff <= res_repeat_count;
         out_status_ff       <= plan_ff.status;
         out_last_ff         <= slot_last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_is_command   = out_is_command_ff;
   assign rsp_bus_value    = out_bus_value_ff;
   assign rsp_repeat_count = out_repeat_count_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_last         = out_last_ff;

endmodule

`default_nettype wire

// ----- src/lcd_draw_command_sequencer.sv -----
// Draw request to panel bus word sequencer, top level.
// A request is parked in the input stage, planned, taken into the emitter's plan
// register, and its words are registered out one per cycle unless rsp_ready stalls;
// a request gives 1, 11 or 12 words, and the next plan is taken with the last word.
// Reset (synchronous, active high) empties both stages, width 320, height 480.
// Depends on lcdseq_pkg, lcdseq_planner and lcdseq_emitter.
`default_nettype none

module lcd_draw_command_sequencer (
   input  wire               clock,
   input  wire               reset,
   // configuration write port
   input  wire               csr_write_enable,
   input  wire               csr_index,
   input  wire [15:0]        csr_write_data,
   // draw requests
   input  wire               req_valid,
   output logic              req_ready,
   input  wire [2:0]         req_kind,
   input  wire signed [15:0] req_x_start,
   input  wire signed [15:0] req_y_start,
   input  wire signed [15:0] req_x_end,
   input  wire signed [15:0] req_y_end,
   input  wire [15:0]        req_color,
   input  wire               req_transparent,
   // panel bus words
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic              rsp_is_command,
   output logic [15:0]       rsp_bus_value,
   output logic [32:0]       rsp_repeat_count,
   output logic              rsp_status,
   output logic              rsp_last
);

   logic [15:0] panel_width_ff, panel_width_in;
   logic [15:0] panel_height_ff, panel_height_in;

   // input stage: one request word parked ahead of the planner
   lcdseq_pkg::request_type req_ff, req_in;
   logic                    req_valid_ff, req_valid_in;
   logic                    req_accept;

   lcdseq_pkg::plan_type plan;
   logic                 plan_take;

   // hold the panel size; writes come only while the block is idle: user rule, unchecked
   always_comb begin
      panel_width_in  = panel_width_ff;
      panel_height_in = panel_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            lcdseq_pkg::CSR_PANEL_WIDTH:  panel_width_in  = csr_write_data;
            lcdseq_pkg::CSR_PANEL_HEIGHT: panel_height_in = csr_write_data;
            default:                      panel_width_in  = panel_width_ff;
         endcase
      end
   end

   // the input stage frees up on the same edge the emitter takes its plan
   assign req_ready  = !req_valid_ff || plan_take;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      req_in.kind        = req_kind;
      req_in.x_start     = req_x_start;
      req_in.y_start     = req_y_start;
      req_in.x_end       = req_x_end;
      req_in.y_end       = req_y_end;
      req_in.color       = req_color;
      req_in.transparent = req_transparent;
      req_valid_in = req_accept ? 1'b1 : (plan_take ? 1'b0 : req_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_width_ff  <= lcdseq_pkg::PANEL_WIDTH_RESET;
         panel_height_ff <= lcdseq_pkg::PANEL_HEIGHT_RESET;
         req_valid_ff    <= 1'b0;
      end else begin
         panel_width_ff  <= panel_width_in;
         panel_height_ff <= panel_height_in;
         req_valid_ff    <= req_valid_in;
      end
   end

   // payload: load on accept, otherwise hold
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_in;
      end
   end

   // sort corners, check the line, multiply out the fill area
   lcdseq_planner u_planner (
      .req          (req_ff),
      .panel_width  (panel_width_ff),
      .panel_height (panel_height_ff),
      .plan         (plan)
   );

   // step the plan out one bus word per cycle, held while the output is stalled
   lcdseq_emitter u_emitter (
      .clock            (clock),
      .reset            (reset),
      .plan_valid       (req_valid_ff),
      .plan             (plan),
      .plan_take        (plan_take),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_command   (rsp_is_command),
      .rsp_bus_value    (rsp_bus_value),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

`ifndef SYNTH
   // a parked request that the emitter did not take stays parked
   a_hold_parked: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !plan_take |=> req_valid_ff)
      else $error("parked request lost before the emitter took it");

   // a command word always strobes once and never reports failure
   a_command_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_command |-> (rsp_repeat_count == 33'd1) && !rsp_status &&
      (rsp_bus_value == lcdseq_pkg::CMD_COLUMN_ADDR ||
       rsp_bus_value == lcdseq_pkg::CMD_PAGE_ADDR ||
       rsp_bus_value == lcdseq_pkg::CMD_MEMORY_WR))
      else $error("malformed command word");

   // a failed request gives a single empty closing word
   a_fail_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_last && (rsp_repeat_count == 33'd0) &&
      !rsp_is_command && (rsp_bus_value == 16'h0000))
      else $error("failure word not empty or not last");

   // the memory-write command either closes the request or precedes a color word
   a_memory_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_is_command &&
      (rsp_bus_value == lcdseq_pkg::CMD_MEMORY_WR) && !rsp_last
      |=> !rsp_valid || (!rsp_is_command && rsp_last))
      else $error("memory-write command not followed by the color word");
`endif

endmodule

`default_nettype wire
